### rtl/msp_pkg.sv
// shared types, constants and character helpers for the memory size string parser
`default_nettype none

package msp_pkg;

  // width of the parsed value; the result port stays 64 bits wide
  localparam int unsigned ValueWidth = 64;
  localparam int unsigned ByteCountWidth = 64;
  localparam int unsigned ShiftWidth = 6;
  localparam int unsigned CharWidth = 8;

  // character codes
  localparam logic [CharWidth-1:0] CharSpace = 8'h20;
  localparam logic [CharWidth-1:0] CharTab = 8'h09;
  localparam logic [CharWidth-1:0] CharCr = 8'h0d;
  localparam logic [CharWidth-1:0] CharMinus = 8'h2d;
  localparam logic [CharWidth-1:0] CharZero = 8'h30;
  localparam logic [CharWidth-1:0] CharNine = 8'h39;

  // result status codes
  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StUnset = 2'd1,
    StBad   = 2'd2
  } status_e;

  // one accepted input request
  typedef struct packed {
    logic [CharWidth-1:0] char_code;
    logic                 has_char;
    logic                 last;
  } item_t;

  // one result request
  typedef struct packed {
    status_e                   status;
    logic [ByteCountWidth-1:0] byte_count;
  } result_t;

  // space and the control codes tab through carriage return
  function automatic logic is_blank(input logic [CharWidth-1:0] c);
    is_blank = (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
  endfunction

  function automatic logic is_digit(input logic [CharWidth-1:0] c);
    is_digit = (c >= CharZero) && (c <= CharNine);
  endfunction

  // binary scale of a size letter, either case; zero for any other code
  function automatic logic [ShiftWidth-1:0] suffix_shift(input logic [CharWidth-1:0] c);
    case (c)
      8'h4b, 8'h6b: suffix_shift = 6'd10;
      8'h4d, 8'h6d: suffix_shift = 6'd20;
      8'h47, 8'h67: suffix_shift = 6'd30;
      8'h54, 8'h74: suffix_shift = 6'd40;
      8'h50, 8'h70: suffix_shift = 6'd50;
      8'h45, 8'h65: suffix_shift = 6'd60;
      default:      suffix_shift = 6'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

### rtl/msp_in_stage.sv
// input register stage: holds one accepted character request
`default_nettype none

module msp_in_stage (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     s_valid_i,
  output logic                          s_ready_o,
  input  wire msp_pkg::item_t           s_item_i,
  input  wire logic                     take_i,
  output logic                          item_valid_o,
  output msp_pkg::item_t                item_o
);
  import msp_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  // room when empty or when the held request moves on this cycle
  assign s_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (s_ready_o) begin
      valid_d = s_valid_i;
    end
  end

  // control register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (s_ready_o && s_valid_i) begin
      item_q <= s_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o = item_q;

`ifndef SYNTH
  // a stalled input side always means a request is parked here
  a_stall_holds_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_ready_o |-> valid_q)
    else $error("input stalled with empty stage");
`endif

endmodule

`default_nettype wire

### rtl/msp_parse.sv
// parse state and single-step character decoding
`default_nettype none

module msp_parse (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     item_valid_i,
  input  wire msp_pkg::item_t           item_i,
  input  wire logic                     out_free_i,
  output logic                          take_o,
  output logic                          res_load_o,
  output msp_pkg::result_t              res_o
);
  import msp_pkg::*;

  typedef enum logic [1:0] {
    PhBefore,
    PhDigits,
    PhSuffix,
    PhAfter
  } phase_e;

  localparam int unsigned ProdWidth = ValueWidth + 4;

  phase_e                  phase_q, phase_d;
  logic                    bad_q, bad_d;
  logic                    minus_q, minus_d;
  logic [1:0]              digits_q, digits_d;
  logic                    first_one_q, first_one_d;
  logic [ValueWidth-1:0]   acc_q, acc_d;
  logic [ShiftWidth-1:0]   shift_q, shift_d;

  logic                    do_digit;
  logic                    digit_c;
  logic [3:0]              digit_val;
  logic [ShiftWidth-1:0]   sfx;
  logic [ProdWidth-1:0]    acc_ext;
  logic [ProdWidth-1:0]    prod;
  logic [ValueWidth-1:0]   fit_mask;
  logic                    shift_too_big;
  status_e                 status;
  logic [ValueWidth-1:0]   scaled;

  // a plain character always moves on; the last one waits for the result slot
  assign take_o = item_valid_i && (!item_i.last || out_free_i);
  assign res_load_o = take_o && item_i.last;

  // decimal step: value times ten plus the digit, with spare high bits
  assign digit_c = is_digit(item_i.char_code);
  assign digit_val = 4'(item_i.char_code - CharZero);
  assign sfx = suffix_shift(item_i.char_code);
  assign acc_ext = ProdWidth'(acc_q);
  assign prod = (acc_ext << 3) + (acc_ext << 1) + ProdWidth'(digit_val);

  // next parse state for one character
  always_comb begin
    phase_d = phase_q;
    bad_d = bad_q;
    minus_d = minus_q;
    digits_d = digits_q;
    first_one_d = first_one_q;
    acc_d = acc_q;
    shift_d = shift_q;
    do_digit = 1'b0;
    if (item_i.has_char) begin
      if (is_blank(item_i.char_code)) begin
        if (phase_q == PhDigits || phase_q == PhSuffix) begin
          phase_d = PhAfter;
        end
      end else begin
        case (phase_q)
          PhBefore: begin
            phase_d = PhDigits;
            if (item_i.char_code == CharMinus) begin
              minus_d = 1'b1;
            end else if (digit_c) begin
              do_digit = 1'b1;
            end else begin
              bad_d = 1'b1;
            end
          end
          PhDigits: begin
            if (digit_c) begin
              do_digit = 1'b1;
            end else if (minus_q || digits_q == 2'd0 || sfx == '0) begin
              bad_d = 1'b1;
            end else begin
              shift_d = sfx;
              phase_d = PhSuffix;
            end
          end
          default: begin
            bad_d = 1'b1;
          end
        endcase
      end
    end
    // digit bookkeeping and accumulation
    if (do_digit) begin
      if (digits_q == 2'd0) begin
        first_one_d = (digit_val == 4'd1);
      end
      if (digits_q != 2'd3) begin
        digits_d = digits_q + 2'd1;
      end
      if (!minus_q && !bad_q) begin
        if (prod[ProdWidth-1:ValueWidth] != '0) begin
          bad_d = 1'b1;
        end else begin
          acc_d = prod[ValueWidth-1:0];
        end
      end
    end
  end

  // scale check: a suffix never shares a cycle with a digit, so the held value is used
  assign fit_mask = ~({ValueWidth{1'b1}} >> shift_d);
  assign shift_too_big = ({1'b0, shift_d} >= (ShiftWidth + 1)'(ValueWidth));
  assign scaled = (shift_d == '0) ? acc_d : (acc_q << shift_d);

  // final status from the updated state
  always_comb begin
    if (phase_d == PhBefore) begin
      status = StUnset;
    end else if (bad_d) begin
      status = StBad;
    end else if (minus_d) begin
      status = (digits_d == 2'd1 && first_one_d) ? StUnset : StBad;
    end else if (digits_d == 2'd0 || shift_too_big) begin
      status = StBad;
    end else if (shift_d != '0 && (acc_q & fit_mask) != '0) begin
      status = StBad;
    end else begin
      status = StOk;
    end
  end

  assign res_o.status = status;
  assign res_o.byte_count = (status == StOk) ? ByteCountWidth'(scaled) : '0;

  // parse state; cleared after every result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhBefore;
      bad_q <= 1'b0;
      minus_q <= 1'b0;
      digits_q <= 2'd0;
      first_one_q <= 1'b0;
      acc_q <= '0;
      shift_q <= '0;
    end else if (take_o) begin
      if (item_i.last) begin
        phase_q <= PhBefore;
        bad_q <= 1'b0;
        minus_q <= 1'b0;
        digits_q <= 2'd0;
        first_one_q <= 1'b0;
        acc_q <= '0;
        shift_q <= '0;
      end else begin
        phase_q <= phase_d;
        bad_q <= bad_d;
        minus_q <= minus_d;
        digits_q <= digits_d;
        first_one_q <= first_one_d;
        acc_q <= acc_d;
        shift_q <= shift_d;
      end
    end
  end

`ifndef SYNTH
  // every string starts from a clean state
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load_o |=> (phase_q == PhBefore) && (acc_q == '0) && (shift_q == '0))
    else $error("parse state not cleared after result");
  // no value without digits
  a_no_digits_no_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (digits_q == 2'd0) |-> (acc_q == '0))
    else $error("accumulator nonzero before any digit");
`endif

endmodule

`default_nettype wire

### rtl/msp_out_stage.sv
// result register stage toward the output stream
`default_nettype none

module msp_out_stage (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     load_i,
  input  wire msp_pkg::result_t         res_i,
  output logic                          free_o,
  output logic                          m_valid_o,
  input  wire logic                     m_ready_i,
  output msp_pkg::result_t              m_res_o
);
  import msp_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  // slot is free when empty or being emptied this cycle
  assign free_o = !valid_q || m_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  // control register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_valid_o = valid_q;
  assign m_res_o = res_q;

`ifndef SYNTH
  // a result other than ok never carries a size
  a_zero_unless_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && (res_q.status != StOk) |-> (res_q.byte_count == '0))
    else $error("nonzero byte count on non-ok result");
`endif

endmodule

`default_nettype wire

### rtl/memory_size_string_parser.sv
// top level of the memory size string parser
// Input stream: one character per request; tdata[7:0] is the byte, tuser[0] says
// the byte is present (low only for an empty string), tlast marks the string end.
// Output stream: one result per string, on the request that carried tlast;
// tuser[1:0] is the status (0 ok, 1 unset, 2 bad), tdata is the size in bytes
// (zero unless ok). Whitespace around the token is dropped; a K/M/G/T/P/E
// suffix in either case scales by 2^10 up to 2^60.
// Throughput: one character per cycle, sustained across string boundaries,
// while results are taken. The last character sits in the input register, then
// its result moves to the result register once that is free, with the single
// decimal multiply-add and overflow check between those registers.
// When the receiver stalls, the finished result waits in the result register;
// characters keep flowing until a second string ends, then the input side
// stalls with that last character parked in the input register.
// Reset clears both stages and the parse state; no result is pending after it.
`default_nettype none

module memory_size_string_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  wire logic [0:0]  s_axis_tuser,   // [0] has_char
  input  wire logic        s_axis_tlast,   // last
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // [63:0] byte_count
  output logic [1:0]       m_axis_tuser    // [1:0] status
);
  import msp_pkg::*;

  item_t   s_item;
  item_t   item;
  logic    item_valid;
  logic    take;
  logic    res_load;
  logic    out_free;
  result_t res;
  result_t m_res;

  // pack the input request
  assign s_item.char_code = s_axis_tdata;
  assign s_item.has_char = s_axis_tuser[0];
  assign s_item.last = s_axis_tlast;

  // input register
  msp_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_item_i     (s_item),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  // parser step
  msp_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .out_free_i   (out_free),
    .take_o       (take),
    .res_load_o   (res_load),
    .res_o        (res)
  );

  // result register
  msp_out_stage u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (res_load),
    .res_i     (res),
    .free_o    (out_free),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_res_o   (m_res)
  );

  // unpack the result request
  assign m_axis_tdata = m_res.byte_count;
  assign m_axis_tuser = m_res.status;

endmodule

`default_nettype wire
